[hw/rtl/assert_macros.svh]
// Assertion macros shared by the frame receiver RTL.
// No dependencies; ASSERT_OFF removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[hw/rtl/ibfr_pkg.sv]
// Package of the inverted bus frame receiver: types, codes, CRC step.
// No dependencies.
package ibfr_pkg;

	localparam int MAX_FRAME_BYTES_DEF = 64;
	localparam int HEAD_BYTES          = 8;

	localparam logic [7:0]  START_RAW   = 8'h23;
	localparam logic [7:0]  START_BYTE  = 8'hDC;
	localparam logic [7:0]  SENDER_ID   = 8'h80;
	localparam logic [7:0]  MIN_LENGTH  = 8'd10;
	localparam logic [7:0]  HDR_BYTES   = 8'd4;
	localparam logic [7:0]  HEAD_END    = 8'd12;
	localparam logic [15:0] CRC_POLY    = 16'h1021;

	// configuration register indexes
	localparam logic REG_OWN_ADDR   = 1'b0;
	localparam logic REG_BCAST_ADDR = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_CRC_ERR    = 3'd0,
		ST_MODE       = 3'd1,
		ST_MODE_UNK   = 3'd2,
		ST_SETPOINT   = 3'd3,
		ST_AMBIENT    = 3'd4,
		ST_AMB_RANGE  = 3'd5,
		ST_UNKNOWN    = 3'd6
	} status_t;

	typedef logic [HEAD_BYTES-1:0][7:0] head_t;

	typedef struct packed {
		status_t     status;
		logic [1:0]  mode;
		logic [1:0]  preset;
		logic [10:0] setpoint;
		logic [15:0] ambient_raw;
		logic        ambient_filtered;
		logic [5:0]  payload_length;
	} res_t;

	// CRC-16 XMODEM, one byte, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

[hw/rtl/ibfr_if.sv]
// Channel interfaces of the frame receiver: byte input, result output, config writes.
// No dependencies.
interface ibfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] raw_byte;

	modport source (output valid, output raw_byte, input ready);
	modport sink (input valid, input raw_byte, output ready);
endinterface

interface ibfr_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [1:0]  mode;
	logic [1:0]  preset;
	logic [10:0] setpoint_half_degrees;
	logic [15:0] ambient_raw;
	logic        ambient_filtered;
	logic [5:0]  payload_length;

	modport source (output valid, output status, output mode, output preset,
		output setpoint_half_degrees, output ambient_raw, output ambient_filtered,
		output payload_length, input ready);
	modport sink (input valid, input status, input mode, input preset,
		input setpoint_half_degrees, input ambient_raw, input ambient_filtered,
		input payload_length, output ready);
endinterface

interface ibfr_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/ibfr_decode.sv]
// Payload decoder: turns the first eight payload bytes into a result.
// Depends on ibfr_pkg.
module ibfr_decode (
	input  ibfr_pkg::head_t   head,
	input  logic [7:0]        plen,
	output ibfr_pkg::res_t    res
);
	import ibfr_pkg::*;

	localparam logic [15:0] REG_SETPOINT = 16'h058E;
	localparam logic [15:0] REG_AMB      = 16'h051E;
	localparam logic [15:0] REG_AMB_FILT = 16'h056A;
	localparam logic [15:0] AMB_MAX      = 16'd3200;

	localparam logic [15:0] CODE_OFF      = 16'h0000;
	localparam logic [15:0] CODE_HEAT_CMF = 16'h0302;
	localparam logic [15:0] CODE_HEAT_ECO = 16'h0201;
	localparam logic [15:0] CODE_AUTO_E1  = 16'h0103;
	localparam logic [15:0] CODE_AUTO_E2  = 16'h0101;
	localparam logic [15:0] CODE_AUTO_C1  = 16'h0102;
	localparam logic [15:0] CODE_AUTO_C2  = 16'h0104;

	logic [15:0] word;
	logic [15:0] reg_id;
	logic [15:0] code;
	logic        mode_hit;
	logic        rd_prefix;
	logic        sp_hit;
	logic        amb_hit;

	assign word   = {head[6], head[7]};
	assign reg_id = {head[3], head[4]};
	assign code   = {head[5], head[6]};

	assign mode_hit  = (plen == 8'd15) && (head[0] == 8'h02) && (head[1] == 8'h2D)
		&& (head[2] == 8'h00) && (head[3] == 8'h02) && (head[4] == 8'h11);
	assign rd_prefix = (plen == 8'd8) && (head[0] == 8'h07) && (head[1] == 8'h2D)
		&& (head[2] == 8'h3D) && (head[5] == 8'h00);
	assign sp_hit    = rd_prefix && (reg_id == REG_SETPOINT);
	assign amb_hit   = rd_prefix && ((reg_id == REG_AMB) || (reg_id == REG_AMB_FILT));

	always_comb begin
		res = '0;
		res.payload_length = plen[5:0];
		res.status = ST_UNKNOWN;
		if (mode_hit) begin
			res.status = ST_MODE;
			case (code)
				CODE_OFF: begin
					res.mode = 2'd0;
					res.preset = 2'd0;
				end
				CODE_HEAT_CMF: begin
					res.mode = 2'd1;
					res.preset = 2'd1;
				end
				CODE_HEAT_ECO: begin
					res.mode = 2'd1;
					res.preset = 2'd2;
				end
				CODE_AUTO_E1, CODE_AUTO_E2: begin
					res.mode = 2'd2;
					res.preset = 2'd2;
				end
				CODE_AUTO_C1, CODE_AUTO_C2: begin
					res.mode = 2'd2;
					res.preset = 2'd1;
				end
				default: begin
					res.status = ST_MODE_UNK;
				end
			endcase
		end else if (sp_hit) begin
			res.status = ST_SETPOINT;
			res.setpoint = word[15:5];
		end else if (amb_hit) begin
			res.status = (word > AMB_MAX) ? ST_AMB_RANGE : ST_AMBIENT;
			res.ambient_raw = word;
			res.ambient_filtered = (reg_id == REG_AMB_FILT);
		end
	end

endmodule

[hw/rtl/inverted_bus_frame_receiver_unit.sv]
// Inverted bus frame receiver, top level.
// Throughput: one byte item per cycle, sustained, while results are taken.
// The result of a frame is registered: its last byte passes the input register,
// then the frame logic into the result register.
// Reset (arst_n low, async): idle, no item held, own address 0, broadcast address 255.
`include "assert_macros.svh"

module inverted_bus_frame_receiver_unit #(
	parameter int MAX_FRAME_BYTES = ibfr_pkg::MAX_FRAME_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	ibfr_cfg_if.sink   cfg,
	ibfr_in_if.sink    rx,
	ibfr_out_if.source res
);
	import ibfr_pkg::*;

	localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME_BYTES);

	// configuration registers
	logic [6:0] own_addr_q;
	logic [7:0] bcast_addr_q;

	// input register
	logic       valid_s1;
	logic [7:0] raw_s1;

	// frame state
	phase_t      phase_q, phase_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  len_q, len_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_hi_q, crc_hi_d;
	logic [7:0]  sender_q, sender_d;
	logic [7:0]  dest_q, dest_d;
	head_t       head_q;
	logic        head_we;
	logic [2:0]  head_idx;

	// result register
	logic res_valid_q;
	res_t res_q;

	logic       stall;
	logic       adv;
	logic       load_res;
	logic [7:0] b;
	logic       hdr_ok;
	logic       crc_ok;
	logic [8:0] pos2;
	logic [7:0] plen;
	res_t       dec_res;
	res_t       res_d;

	// ---------------- configuration port ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= '0;
			bcast_addr_q <= 8'hFF;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_OWN_ADDR:   own_addr_q <= cfg.data[6:0];
				REG_BCAST_ADDR: bcast_addr_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---------------- input register ----------------
	// The frame stage only stalls when it holds a result nobody has taken;
	// the input register then still takes one more item if it is empty.
	assign stall    = res_valid_q && !res.ready;
	assign adv      = valid_s1 && !stall;
	assign rx.ready = !valid_s1 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			raw_s1 <= rx.raw_byte;
		end
	end

	// ---------------- frame sequencer ----------------
	assign b    = ~raw_s1;
	assign pos2 = {1'b0, cnt_q} + 9'd2;   // compared with the frame length
	assign plen = len_q - 8'd6;

	// header check on the length byte; sender and destination were kept earlier
	assign hdr_ok = (sender_q == SENDER_ID)
		&& ((dest_q == {1'b0, own_addr_q}) || (dest_q == bcast_addr_q))
		&& (b >= MIN_LENGTH) && (b <= MAX_LEN);

	assign head_idx = 3'(cnt_q - HDR_BYTES);

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		len_d    = len_q;
		crc_d    = crc_q;
		crc_hi_d = crc_hi_q;
		sender_d = sender_q;
		dest_d   = dest_q;
		head_we  = 1'b0;
		load_res = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				crc_d = crc_byte(crc_q, b);
				cnt_d = cnt_q + 8'd1;
				if (cnt_q == 8'd1) begin
					sender_d = b;
				end else if (cnt_q == 8'd2) begin
					dest_d = b;
				end else if (hdr_ok) begin
					len_d = b;
					phase_d = PH_PAYLOAD;
				end else begin
					// bad header: drop the frame silently
					phase_d = PH_IDLE;
					cnt_d = '0;
				end
			end
			PH_PAYLOAD: begin
				cnt_d = cnt_q + 8'd1;
				if (pos2 < {1'b0, len_q}) begin
					crc_d = crc_byte(crc_q, b);
					head_we = (cnt_q >= HDR_BYTES) && (cnt_q < HEAD_END);
				end else if (pos2 == {1'b0, len_q}) begin
					crc_hi_d = b;
				end else begin
					// CRC low byte: end of frame
					phase_d = PH_IDLE;
					cnt_d = '0;
					load_res = 1'b1;
				end
			end
			default: begin
				// idle and the unused phase code
				phase_d = PH_IDLE;
				if (raw_s1 == START_RAW) begin
					crc_d = crc_byte(16'h0000, START_BYTE);
					cnt_d = 8'd1;
					sender_d = '0;
					dest_d = '0;
					phase_d = PH_HEADER;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cnt_q    <= '0;
			len_q    <= '0;
			crc_q    <= '0;
			crc_hi_q <= '0;
			sender_q <= '0;
			dest_q   <= '0;
		end else if (adv) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			len_q    <= len_d;
			crc_q    <= crc_d;
			crc_hi_q <= crc_hi_d;
			sender_q <= sender_d;
			dest_q   <= dest_d;
		end
	end

	// first eight payload bytes; a shorter frame writes only the bytes it has
	always_ff @(posedge clk) begin
		if (adv && head_we) begin
			head_q[head_idx] <= b;
		end
	end

	// ---------------- result ----------------
	ibfr_decode u_decode (
		.head (head_q),
		.plen (plen),
		.res  (dec_res)
	);

	assign crc_ok = (crc_hi_q == crc_q[15:8]) && (b == crc_q[7:0]);

	always_comb begin
		res_d = '0;
		res_d.status = ST_CRC_ERR;
		res_d.payload_length = plen[5:0];
		if (crc_ok) begin
			res_d = dec_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && load_res) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && load_res) begin
			res_q <= res_d;
		end
	end

	assign res.valid                 = res_valid_q;
	assign res.status                = res_q.status;
	assign res.mode                  = res_q.mode;
	assign res.preset                = res_q.preset;
	assign res.setpoint_half_degrees = res_q.setpoint;
	assign res.ambient_raw           = res_q.ambient_raw;
	assign res.ambient_filtered      = res_q.ambient_filtered;
	assign res.payload_length        = res_q.payload_length;

	// ---------------- checks ----------------
	`ASSERT_PROP(a_res_only_in_payload, clk, arst_n, (adv && load_res) |-> (phase_q == PH_PAYLOAD), "result outside payload phase")
	`ASSERT_PROP(a_idle_after_frame, clk, arst_n, (adv && load_res) |=> (phase_q == PH_IDLE && cnt_q == 8'd0), "not idle after frame end")
	`ASSERT_PROP(a_payload_bounds, clk, arst_n, (phase_q == PH_PAYLOAD) |-> (cnt_q < len_q && len_q >= MIN_LENGTH && len_q <= MAX_LEN), "payload counter out of frame")
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, stall && adv, "pending result overwritten")

endmodule
